### rtl/ctb_pkg.sv
// ----------------------------------------------------------------------------
// ctb_pkg
// Shared types and codes of the counted binary trie max-xor unit.
// ----------------------------------------------------------------------------
package ctb_pkg;

	localparam int KEY_W = 34;

	typedef logic [1:0] cmd_t;
	typedef logic [1:0] status_t;

	localparam cmd_t CMD_INSERT = 2'd0;
	localparam cmd_t CMD_REMOVE = 2'd1;
	localparam cmd_t CMD_QUERY  = 2'd2;
	localparam cmd_t CMD_CLEAR  = 2'd3;

	localparam status_t STAT_OK       = 2'd0;
	localparam status_t STAT_FULL     = 2'd1;
	localparam status_t STAT_ABSENT   = 2'd2;
	localparam status_t STAT_OVERFLOW = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic dispatch;
		logic chk_issue;
		logic chk_eval;
		logic decide;
		logic mut_issue;
		logic mut_write;
		logic q_issue;
		logic q_child;
		logic q_eval;
		logic load_out;
	} ctb_ctl_t;

	// datapath -> controller
	typedef struct packed {
		cmd_t cmd;
		logic used_zero;
		logic chk_stop;
		logic go;
		logic mut_last;
		logic next_new;
		logic q_empty;
		logic q_stop;
	} ctb_sts_t;

endpackage

### rtl/ctb_in_if.sv
// ----------------------------------------------------------------------------
// ctb_in_if
// Command channel: valid/ready with command and key.
// ----------------------------------------------------------------------------
interface ctb_in_if;
	import ctb_pkg::*;

	logic              valid;
	logic              ready;
	cmd_t              command;
	logic [KEY_W-1:0]  key;

	modport source (output valid, output command, output key, input ready);
	modport sink   (input valid, input command, input key, output ready);
endinterface

### rtl/ctb_out_if.sv
// ----------------------------------------------------------------------------
// ctb_out_if
// Result channel: valid/ready with best_xor, set_empty and status.
// ----------------------------------------------------------------------------
interface ctb_out_if;
	import ctb_pkg::*;

	logic              valid;
	logic              ready;
	logic [KEY_W-1:0]  best_xor;
	logic              set_empty;
	status_t           status;

	modport source (output valid, output best_xor, output set_empty, output status,
		input ready);
	modport sink   (input valid, input best_xor, input set_empty, input status,
		output ready);
endinterface

### rtl/ctb_ram.sv
// ----------------------------------------------------------------------------
// ctb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ctb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### rtl/ctb_datapath.sv
// ----------------------------------------------------------------------------
// ctb_datapath
// Node memories, walk registers, pool counter and result registers.
// ----------------------------------------------------------------------------
module ctb_datapath #(
	parameter int KEY_BITS   = 34,
	parameter int POOL_NODES = 65536,
	parameter int COUNT_BITS = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ctb_pkg::ctb_ctl_t         ctl,
	output ctb_pkg::ctb_sts_t         sts,
	input  ctb_pkg::cmd_t             in_command,
	input  logic [ctb_pkg::KEY_W-1:0] in_key,
	output logic [ctb_pkg::KEY_W-1:0] out_best_xor,
	output logic                      out_set_empty,
	output ctb_pkg::status_t          out_status
);
	import ctb_pkg::*;

	localparam int NW     = $clog2(POOL_NODES);
	localparam int UW     = NW + 1;
	localparam int DW     = $clog2(KEY_BITS + 1);
	localparam int NEED_W = $clog2(KEY_BITS + 2);
	localparam logic [KEY_BITS-1:0] TOP_BIT = KEY_BITS'(1) << (KEY_BITS - 1);

	cmd_t                  cmd_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [KEY_BITS-1:0]   acc_q;
	logic [NW-1:0]         node_q;
	logic [DW-1:0]         depth_q;
	logic [UW-1:0]         used_q;
	logic [NEED_W-1:0]     need_q;
	logic [COUNT_BITS-1:0] root_cnt_q;
	logic [COUNT_BITS-1:0] leaf_cnt_q;
	logic                  miss_q;
	logic                  new_q;
	logic [NW-1:0]         want_q;
	logic [NW-1:0]         same_q;
	logic                  empty_q;
	status_t               stat_q;

	logic [NW-1:0]         c0_rd, c1_rd;
	logic [COUNT_BITS-1:0] cnt_rd;

	logic [KEY_BITS-1:0]   key_sh;
	logic                  key_bit;
	logic [NW-1:0]         child_sel, child_oth;
	logic                  at_leaf;
	logic                  is_ins;
	logic [UW-1:0]         pool_left;
	logic                  ins_ovf, ins_full, rem_absent;

	logic [NW-1:0]         old_c0, old_c1, old_sel;
	logic [COUNT_BITS-1:0] old_cnt;
	logic                  alloc;
	logic [NW-1:0]         next_node;
	logic [NW-1:0]         wr_c0, wr_c1;
	logic [COUNT_BITS-1:0] wr_cnt;
	logic                  take;

	logic                  rd_en;
	logic [NW-1:0]         cnt_raddr;

	assign key_sh    = key_q << depth_q;
	assign key_bit   = key_sh[KEY_BITS-1];
	assign child_sel = key_bit ? c1_rd : c0_rd;
	assign child_oth = key_bit ? c0_rd : c1_rd;
	assign at_leaf   = (depth_q == DW'(KEY_BITS));
	assign is_ins    = (cmd_q == CMD_INSERT);

	assign pool_left  = UW'(POOL_NODES) - used_q;
	assign ins_ovf    = (used_q != '0) && (root_cnt_q == '1);
	assign ins_full   = UW'(need_q) > pool_left;
	assign rem_absent = miss_q || (leaf_cnt_q == '0);

	// a freshly allocated node reads as all zeros
	assign old_c0    = new_q ? '0 : c0_rd;
	assign old_c1    = new_q ? '0 : c1_rd;
	assign old_cnt   = new_q ? '0 : cnt_rd;
	assign old_sel   = key_bit ? old_c1 : old_c0;
	assign alloc     = is_ins && !at_leaf && (new_q || (old_sel == '0));
	assign next_node = alloc ? used_q[NW-1:0] : old_sel;
	assign wr_c0     = (alloc && !key_bit) ? next_node : old_c0;
	assign wr_c1     = (alloc && key_bit) ? next_node : old_c1;
	assign wr_cnt    = is_ins ? old_cnt + COUNT_BITS'(1) : old_cnt - COUNT_BITS'(1);

	assign take = (want_q != '0) && (cnt_rd != '0);

	assign rd_en     = ctl.chk_issue || ctl.mut_issue || ctl.q_issue;
	assign cnt_raddr = ctl.q_child ? child_oth : node_q;

	ctb_ram #(.WIDTH(COUNT_BITS), .DEPTH(POOL_NODES)) u_count (
		.clk   (clk),
		.we    (ctl.mut_write),
		.waddr (node_q),
		.wdata (wr_cnt),
		.re    (rd_en || ctl.q_child),
		.raddr (cnt_raddr),
		.rdata (cnt_rd)
	);

	ctb_ram #(.WIDTH(NW), .DEPTH(POOL_NODES)) u_child_zero (
		.clk   (clk),
		.we    (ctl.mut_write),
		.waddr (node_q),
		.wdata (wr_c0),
		.re    (rd_en),
		.raddr (node_q),
		.rdata (c0_rd)
	);

	ctb_ram #(.WIDTH(NW), .DEPTH(POOL_NODES)) u_child_one (
		.clk   (clk),
		.we    (ctl.mut_write),
		.waddr (node_q),
		.wdata (wr_c1),
		.re    (rd_en),
		.raddr (node_q),
		.rdata (c1_rd)
	);

	always_comb begin
		sts.cmd       = cmd_q;
		sts.used_zero = (used_q == '0);
		sts.chk_stop  = at_leaf || (child_sel == '0);
		sts.go        = is_ins ? !(ins_ovf || ins_full) : !rem_absent;
		sts.mut_last  = at_leaf;
		sts.next_new  = alloc;
		sts.q_empty   = (depth_q == '0) && (cnt_rd == '0);
		sts.q_stop    = (depth_q == DW'(KEY_BITS - 1)) || (!take && (same_q == '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (ctl.dispatch && (cmd_q == CMD_CLEAR)) begin
			used_q <= '0;
		end else if (ctl.decide && is_ins && sts.go && (used_q == '0)) begin
			used_q <= UW'(1);
		end else if (ctl.mut_write && alloc) begin
			used_q <= used_q + UW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q   <= in_command;
			key_q   <= KEY_BITS'(64'(in_key));
			acc_q   <= '0;
			node_q  <= '0;
			depth_q <= '0;
			need_q  <= '0;
			miss_q  <= 1'b0;
			new_q   <= 1'b0;
			empty_q <= 1'b0;
			stat_q  <= STAT_OK;
		end
		if (ctl.dispatch && (used_q == '0)) begin
			case (cmd_q)
				CMD_INSERT: need_q  <= NEED_W'(KEY_BITS + 1);
				CMD_REMOVE: stat_q  <= STAT_ABSENT;
				CMD_QUERY:  empty_q <= 1'b1;
				default:    ;
			endcase
		end
		if (ctl.chk_eval) begin
			if (depth_q == '0) begin
				root_cnt_q <= cnt_rd;
			end
			if (at_leaf) begin
				leaf_cnt_q <= cnt_rd;
			end else if (child_sel == '0) begin
				miss_q <= 1'b1;
				need_q <= NEED_W'(KEY_BITS) - NEED_W'(depth_q);
			end else begin
				node_q  <= child_sel;
				depth_q <= depth_q + DW'(1);
			end
		end
		if (ctl.decide) begin
			node_q  <= '0;
			depth_q <= '0;
			new_q   <= is_ins && (used_q == '0);
			if (is_ins) begin
				if (ins_ovf) begin
					stat_q <= STAT_OVERFLOW;
				end else if (ins_full) begin
					stat_q <= STAT_FULL;
				end
			end else if (rem_absent) begin
				stat_q <= STAT_ABSENT;
			end
		end
		if (ctl.mut_write) begin
			node_q  <= next_node;
			depth_q <= depth_q + DW'(1);
			new_q   <= alloc;
		end
		if (ctl.q_child) begin
			if (sts.q_empty) begin
				empty_q <= 1'b1;
			end
			want_q <= child_oth;
			same_q <= child_sel;
		end
		if (ctl.q_eval) begin
			depth_q <= depth_q + DW'(1);
			if (take) begin
				acc_q  <= acc_q | (TOP_BIT >> depth_q);
				node_q <= want_q;
			end else begin
				node_q <= same_q;
			end
		end
		if (ctl.load_out) begin
			out_best_xor  <= (cmd_q == CMD_QUERY && !empty_q) ? KEY_W'(64'(acc_q)) : '0;
			out_set_empty <= empty_q;
			out_status    <= stat_q;
		end
	end
endmodule

### rtl/ctb_ctrl.sv
// ----------------------------------------------------------------------------
// ctb_ctrl
// Sequencer of the trie walks and owner of the channel handshakes.
// ----------------------------------------------------------------------------
module ctb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output ctb_pkg::ctb_ctl_t ctl,
	input  ctb_pkg::ctb_sts_t sts
);
	import ctb_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DISP   = 4'd1;
	localparam logic [3:0] S_CHK_RD = 4'd2;
	localparam logic [3:0] S_CHK_EV = 4'd3;
	localparam logic [3:0] S_DECIDE = 4'd4;
	localparam logic [3:0] S_MUT_RD = 4'd5;
	localparam logic [3:0] S_MUT_WR = 4'd6;
	localparam logic [3:0] S_Q_RD   = 4'd7;
	localparam logic [3:0] S_Q_CH   = 4'd8;
	localparam logic [3:0] S_Q_EV   = 4'd9;
	localparam logic [3:0] S_DONE   = 4'd10;

	logic [3:0] state_q, state_nx;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		ctl           = '0;
		ctl.accept    = (state_q == S_IDLE) && in_valid;
		ctl.dispatch  = (state_q == S_DISP);
		ctl.chk_issue = (state_q == S_CHK_RD);
		ctl.chk_eval  = (state_q == S_CHK_EV);
		ctl.decide    = (state_q == S_DECIDE);
		ctl.mut_issue = (state_q == S_MUT_RD);
		ctl.mut_write = (state_q == S_MUT_WR);
		ctl.q_issue   = (state_q == S_Q_RD);
		ctl.q_child   = (state_q == S_Q_CH);
		ctl.q_eval    = (state_q == S_Q_EV);
		ctl.load_out  = (state_q == S_DONE) && slot_free;
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_nx = S_DISP;
			end
			S_DISP: begin
				case (sts.cmd)
					CMD_INSERT: state_nx = sts.used_zero ? S_DECIDE : S_CHK_RD;
					CMD_REMOVE: state_nx = sts.used_zero ? S_DONE : S_CHK_RD;
					CMD_QUERY:  state_nx = sts.used_zero ? S_DONE : S_Q_RD;
					default:    state_nx = S_DONE;
				endcase
			end
			S_CHK_RD: state_nx = S_CHK_EV;
			S_CHK_EV: state_nx = sts.chk_stop ? S_DECIDE : S_CHK_RD;
			S_DECIDE: begin
				if (!sts.go) state_nx = S_DONE;
				else state_nx = sts.used_zero ? S_MUT_WR : S_MUT_RD;
			end
			S_MUT_RD: state_nx = S_MUT_WR;
			S_MUT_WR: begin
				if (sts.mut_last) state_nx = S_DONE;
				else state_nx = sts.next_new ? S_MUT_WR : S_MUT_RD;
			end
			S_Q_RD: state_nx = S_Q_CH;
			S_Q_CH: state_nx = sts.q_empty ? S_DONE : S_Q_EV;
			S_Q_EV: state_nx = sts.q_stop ? S_DONE : S_Q_RD;
			S_DONE: begin
				if (slot_free) state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			// hold the beat until taken, reload on a finished command
			if (ctl.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |-> (!out_valid_q || out_ready))
		else $error("result overwritten while stalled");

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_DISP))
		else $error("accepted beat not dispatched");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside completion");
`endif
endmodule

### rtl/counted_binary_trie_max_xor_unit.sv
// ----------------------------------------------------------------------------
// counted_binary_trie_max_xor_unit
// Multiset of keys kept as a counted binary trie, with max-xor query.
// ----------------------------------------------------------------------------
// Usage: one command beat on req (insert, remove, query, clear) yields exactly
// one result beat on rsp (best_xor, set_empty, status). One command is in work
// at a time; req.ready is high only while the unit is idle.
// Steps per command, with K = KEY_BITS:
//   insert  a check walk and an update walk, each over K + 1 levels,
//           through the node memories' registered read port; a freshly
//           allocated node skips the read;
//   remove  the same check walk and update walk;
//   query   per level the children read, then the opposite child's
//           count, then the step decision;
//   clear   no walk. Errors end early, before the update walk.
// Reset clears the node pool (nothing stored) and the result valid flag; the
// node memories need no clearing, since only allocated nodes are read.
// A stalled receiver holds the result beat on rsp; the next command is still
// accepted and worked, and its result waits until the held beat is taken.
module counted_binary_trie_max_xor_unit #(
	parameter int KEY_BITS   = 34,
	parameter int POOL_NODES = 65536,
	parameter int COUNT_BITS = 24
) (
	input logic clk,
	input logic arst_n,
	ctb_in_if.sink    req,
	ctb_out_if.source rsp
);
	import ctb_pkg::*;

	ctb_ctl_t ctl;
	ctb_sts_t sts;

	ctb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.ctl       (ctl),
		.sts       (sts)
	);

	ctb_datapath #(
		.KEY_BITS   (KEY_BITS),
		.POOL_NODES (POOL_NODES),
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.in_command    (req.command),
		.in_key        (req.key),
		.out_best_xor  (rsp.best_xor),
		.out_set_empty (rsp.set_empty),
		.out_status    (rsp.status)
	);
endmodule
